// ===== src/tcid_pkg.sv =====
// Shared constants and types for the tile color index and deduplication block.
`timescale 1ns / 1ps

package tcid_pkg;

  // Dictionary depth and tile size.
  localparam int MAX_TILES   = 256;
  localparam int TILE_PIXELS = 64;

  // Field widths.
  localparam int COLOR_W   = 24;
  localparam int CIDX_W    = $clog2(TILE_PIXELS);
  localparam int TNUM_W    = 8;
  localparam int PAT_W     = TILE_PIXELS * CIDX_W;
  localparam int TIDX_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int STORED_W  = $clog2(MAX_TILES + 1);
  localparam int CCNT_W    = $clog2(TILE_PIXELS + 1);
  localparam int SCAN_W    = (STORED_W > CCNT_W) ? STORED_W : CCNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_TSCAN
  } state_e;

endpackage

// ===== src/tcid_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tcid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tile_color_index_dedup_top.sv =====
// Top level: per-tile color indexing and tile pattern deduplication.
//
//   Channel   Ports                                      Handshake
//   -------   ----------------------------------------   ---------------------------
//   request   pixel_color_i                              start_i high, busy_o low
//   result    color_index_o, tile_done_o, tile_number_o, result_valid_o, one cycle
//             tile_is_new_o, dictionary_overflow_o
//
// A pixel's color is compared against the C colors already seen in the tile; one shared scan
// counter walks the color RAM one entry per cycle. The last pixel of a tile then also has the
// same scan walk the S stored patterns of the dictionary RAM, one row per cycle.
// Reset clears the counters and the sequencer; RAM contents need no clearing.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`timescale 1ns / 1ps

module tile_color_index_dedup_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [tcid_pkg::COLOR_W-1:0] pixel_color_i,
  output logic                        result_valid_o,
  output logic [tcid_pkg::CIDX_W-1:0] color_index_o,
  output logic                        tile_done_o,
  output logic [tcid_pkg::TNUM_W-1:0] tile_number_o,
  output logic                        tile_is_new_o,
  output logic                        dictionary_overflow_o
);

  import tcid_pkg::*;

  state_e state_q, state_d;

  logic [COLOR_W-1:0]  color_q, color_d;
  logic [CCNT_W-1:0]   ccount_q, ccount_d;
  logic [CIDX_W-1:0]   pos_q, pos_d;
  logic [PAT_W-1:0]    pat_q, pat_d;
  logic [STORED_W-1:0] stored_q, stored_d;
  logic [SCAN_W-1:0]   k_q, k_d;
  logic                cvld_q, cvld_d;

  logic                res_vld_q, res_vld_d;
  logic [CIDX_W-1:0]   cidx_q, cidx_d;
  logic                done_q, done_d;
  logic [TNUM_W-1:0]   tnum_q, tnum_d;
  logic                new_q, new_d;
  logic                ovf_q, ovf_d;

  logic                cram_we, cram_re;
  logic [COLOR_W-1:0]  cram_rdata;
  logic                dram_we, dram_re;
  logic [PAT_W-1:0]    dram_rdata;

  logic [SCAN_W-1:0]   scan_limit;
  logic [SCAN_W-1:0]   k_prev;
  logic                scan_more;
  logic                cmatch, tmatch;
  logic                fin_c;
  logic [CIDX_W-1:0]   idx_c;

  tcid_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(TILE_PIXELS)
  ) u_color_ram (
    .clk_i  (clk_i),
    .we_i   (cram_we),
    .waddr_i(ccount_q[CIDX_W-1:0]),
    .wdata_i(color_q),
    .re_i   (cram_re),
    .raddr_i(k_q[CIDX_W-1:0]),
    .rdata_o(cram_rdata)
  );

  tcid_ram #(
    .WIDTH(PAT_W),
    .DEPTH(MAX_TILES)
  ) u_dict_ram (
    .clk_i  (clk_i),
    .we_i   (dram_we),
    .waddr_i(stored_q[TIDX_W-1:0]),
    .wdata_i(pat_q),
    .re_i   (dram_re),
    .raddr_i(k_q[TIDX_W-1:0]),
    .rdata_o(dram_rdata)
  );

  // The scan counter is shared by the color search and the dictionary walk.
  assign scan_limit = (state_q == ST_CSCAN) ? SCAN_W'(ccount_q) : SCAN_W'(stored_q);
  assign scan_more  = (k_q < scan_limit);
  assign k_prev     = k_q - SCAN_W'(1);
  assign cmatch     = cvld_q && (cram_rdata == color_q);
  assign tmatch     = cvld_q && (dram_rdata == pat_q);

  always_comb begin
    state_d   = state_q;
    color_d   = color_q;
    ccount_d  = ccount_q;
    pos_d     = pos_q;
    pat_d     = pat_q;
    stored_d  = stored_q;
    k_d       = k_q;
    cvld_d    = cvld_q;
    res_vld_d = 1'b0;
    cidx_d    = cidx_q;
    done_d    = done_q;
    tnum_d    = tnum_q;
    new_d     = new_q;
    ovf_d     = ovf_q;
    cram_we   = 1'b0;
    cram_re   = 1'b0;
    dram_we   = 1'b0;
    dram_re   = 1'b0;
    fin_c     = 1'b0;
    idx_c     = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          color_d = pixel_color_i;
          k_d     = '0;
          cvld_d  = 1'b0;
          state_d = ST_CSCAN;
        end
      end

      ST_CSCAN: begin
        // While entries remain, a read is issued each cycle; the data of the previous address is compared.
        if (cmatch) begin
          idx_c = k_prev[CIDX_W-1:0];
          fin_c = 1'b1;
        end else if (scan_more) begin
          cram_re = 1'b1;
          k_d     = k_q + SCAN_W'(1);
          cvld_d  = 1'b1;
        end else if (cvld_q) begin
          cvld_d = 1'b0;
        end else begin
          // Unseen color: append it, unless the table is already full.
          if (ccount_q < CCNT_W'(TILE_PIXELS)) begin
            cram_we  = 1'b1;
            idx_c    = ccount_q[CIDX_W-1:0];
            ccount_d = ccount_q + CCNT_W'(1);
          end
          fin_c = 1'b1;
        end

        if (fin_c) begin
          pat_d  = {pat_q[PAT_W-CIDX_W-1:0], idx_c};
          cidx_d = idx_c;
          done_d = 1'b0;
          tnum_d = '0;
          new_d  = 1'b0;
          ovf_d  = 1'b0;
          if (pos_q == CIDX_W'(TILE_PIXELS - 1)) begin
            k_d     = '0;
            cvld_d  = 1'b0;
            state_d = ST_TSCAN;
          end else begin
            pos_d     = pos_q + CIDX_W'(1);
            res_vld_d = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end

      ST_TSCAN: begin
        if (tmatch) begin
          tnum_d = TNUM_W'(k_prev);
          fin_c  = 1'b1;
        end else if (scan_more) begin
          dram_re = 1'b1;
          k_d     = k_q + SCAN_W'(1);
          cvld_d  = 1'b1;
        end else if (cvld_q) begin
          cvld_d = 1'b0;
        end else begin
          if (stored_q < STORED_W'(MAX_TILES)) begin
            dram_we  = 1'b1;
            tnum_d   = TNUM_W'(stored_q);
            new_d    = 1'b1;
            stored_d = stored_q + STORED_W'(1);
          end else begin
            ovf_d  = 1'b1;
            tnum_d = '0;
          end
          fin_c = 1'b1;
        end

        if (fin_c) begin
          done_d    = 1'b1;
          res_vld_d = 1'b1;
          ccount_d  = '0;
          pos_d     = '0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ccount_q  <= '0;
      pos_q     <= '0;
      stored_q  <= '0;
      k_q       <= '0;
      cvld_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ccount_q  <= ccount_d;
      pos_q     <= pos_d;
      stored_q  <= stored_d;
      k_q       <= k_d;
      cvld_q    <= cvld_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    pat_q   <= pat_d;
    cidx_q  <= cidx_d;
    done_q  <= done_d;
    tnum_q  <= tnum_d;
    new_q   <= new_d;
    ovf_q   <= ovf_d;
  end

  assign busy_o                = (state_q != ST_IDLE);
  assign result_valid_o        = res_vld_q;
  assign color_index_o         = cidx_q;
  assign tile_done_o           = done_q;
  assign tile_number_o         = tnum_q;
  assign tile_is_new_o         = new_q;
  assign dictionary_overflow_o = ovf_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Accepted request did not make the block busy.");

  a_tile_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && tile_done_o) |-> (pos_q == '0 && ccount_q == '0))
    else $error("Tile end did not clear the position and color count.");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && dictionary_overflow_o) |-> (stored_q == STORED_W'(MAX_TILES)))
    else $error("Overflow reported while the dictionary has room.");

  a_new_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && tile_is_new_o) |->
      (tile_done_o && !dictionary_overflow_o && stored_q != '0))
    else $error("New tile flag is inconsistent with the other tile fields.");

  a_index_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !tile_done_o) |-> (CCNT_W'(color_index_o) < ccount_q))
    else $error("Color index beyond the colors seen in this tile.");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("Result strobe while the block is still busy.");

endmodule
